@@ rtl/jdt_pkg.sv @@
// ----------------------------------------------------------------------------
// jdt_pkg
// Shared types and constants of the Jaccard distance threshold unit.
// ----------------------------------------------------------------------------
package jdt_pkg;

  localparam int CMD_W        = 2;
  localparam int LABEL_PORT_W = 32;
  localparam int EPS_W        = 17;
  localparam int FRAC_BITS    = 16;
  localparam int ICNT_W       = 7;
  localparam int UCNT_W       = 8;

  localparam logic [EPS_W-1:0] ONE_FIX   = EPS_W'(65536);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(32768);

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_A  = 2'd3;

  typedef enum logic [1:0] {
    OP_APPEND_A,
    OP_APPEND_B,
    OP_COMPUTE,
    OP_CLEAR_A
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [LABEL_PORT_W-1:0] label;
  } req_t;

  typedef struct packed {
    logic [ICNT_W-1:0] intersection_count;
    logic [UCNT_W-1:0] union_count;
    logic              is_neighbour;
    logic              overflow;
  } res_t;

endpackage

@@ rtl/jdt_ram.sv @@
// ----------------------------------------------------------------------------
// jdt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module jdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/jdt_front.sv @@
// ----------------------------------------------------------------------------
// jdt_front
// Accepts requests, decodes the command and buffers them in a short queue.
// ----------------------------------------------------------------------------
module jdt_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [jdt_pkg::CMD_W-1:0]          cmd_i,
  input  logic [jdt_pkg::LABEL_PORT_W-1:0]   label_i,
  output logic                               req_valid_o,
  input  logic                               req_ready_i,
  output jdt_pkg::req_t                      req_o
);
  import jdt_pkg::*;

  localparam int QDEPTH = 2;

  req_t       ent_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.label = label_i;
    unique case (cmd_i)
      CMD_APPEND_A: dec.op = OP_APPEND_A;
      CMD_APPEND_B: dec.op = OP_APPEND_B;
      CMD_COMPUTE:  dec.op = OP_COMPUTE;
      default:      dec.op = OP_CLEAR_A;
    endcase
  end

  assign full        = (cnt_q == 2'(QDEPTH));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = ent_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= dec;
    end
  end

endmodule

@@ rtl/jdt_back.sv @@
// ----------------------------------------------------------------------------
// jdt_back
// Executes queued requests: label appends, the merge walk and the threshold
// test, and holds the result register.
// ----------------------------------------------------------------------------
module jdt_back #(
  parameter int MAX_LABELS = 64,
  parameter int LABEL_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  jdt_pkg::req_t              req_i,
  input  logic                       eps_we_i,
  input  logic [jdt_pkg::EPS_W-1:0]  eps_i,
  output logic                       res_valid_o,
  input  logic                       res_pop_i,
  output jdt_pkg::res_t              res_o
);
  import jdt_pkg::*;

  localparam int CW = $clog2(MAX_LABELS + 1);
  localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int UW = $clog2(2 * MAX_LABELS + 1);
  localparam int PW = EPS_W + UW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         size_a_q, size_a_d, size_b_q, size_b_d;
  logic [CW-1:0]         idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [CW-1:0]         match_q, match_d;
  logic [UW-1:0]         uni_q, uni_d, diff_q, diff_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic                  ovf_q, ovf_d, ovf_rep_q, ovf_rep_d;
  logic [EPS_W-1:0]      eps_q;
  res_t                  res_q, res_d;
  logic                  res_valid_q, res_valid_d;
  logic                  take, load, a_full, b_full, a_we, b_we;
  logic [LABEL_BITS-1:0] wdata, a_rdata, b_rdata;
  logic [PW-1:0]         lhs;

  assign req_ready_o = (state_q == ST_IDLE);
  assign take        = req_valid_i && req_ready_o;
  assign a_full      = (size_a_q >= CW'(MAX_LABELS));
  assign b_full      = (size_b_q >= CW'(MAX_LABELS));
  assign a_we        = take && (req_i.op == OP_APPEND_A) && !a_full;
  assign b_we        = take && (req_i.op == OP_APPEND_B) && !b_full;
  assign wdata       = LABEL_BITS'(req_i.label);
  assign load        = (state_q == ST_DONE) && (!res_valid_q || res_pop_i);
  assign lhs         = PW'(diff_q) << FRAC_BITS;

  jdt_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_LABELS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (size_a_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_a_d[AW-1:0]),
    .rdata_o (a_rdata)
  );

  jdt_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_LABELS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (size_b_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_b_d[AW-1:0]),
    .rdata_o (b_rdata)
  );

  always_comb begin
    state_d     = state_q;
    size_a_d    = size_a_q;
    size_b_d    = size_b_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    match_d     = match_q;
    uni_d       = uni_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    ovf_d       = ovf_q;
    ovf_rep_d   = ovf_rep_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_pop_i;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (req_i.op)
            OP_APPEND_A: begin
              if (a_full) ovf_d = 1'b1;
              else        size_a_d = size_a_q + CW'(1);
            end
            OP_APPEND_B: begin
              if (b_full) ovf_d = 1'b1;
              else        size_b_d = size_b_q + CW'(1);
            end
            OP_COMPUTE: begin
              idx_a_d   = '0;
              idx_b_d   = '0;
              match_d   = '0;
              ovf_rep_d = ovf_q;
              ovf_d     = 1'b0;
              state_d   = ST_WALK;
            end
            default: begin
              size_a_d = '0;
              ovf_d    = 1'b0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if ((idx_a_q < size_a_q) && (idx_b_q < size_b_q)) begin
          if (a_rdata == b_rdata) begin
            match_d = match_q + CW'(1);
            idx_a_d = idx_a_q + CW'(1);
            idx_b_d = idx_b_q + CW'(1);
          end else if (a_rdata < b_rdata) begin
            idx_b_d = idx_b_q + CW'(1);
          end else begin
            idx_a_d = idx_a_q + CW'(1);
          end
        end else begin
          uni_d    = UW'(size_a_q) + UW'(size_b_q) - UW'(match_q);
          size_b_d = '0;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        prod_d  = PW'(eps_q) * PW'(uni_q);
        diff_d  = uni_q - UW'(match_q);
        state_d = ST_DONE;
      end
      default: begin
        if (load) begin
          res_d.intersection_count = ICNT_W'(match_q);
          res_d.union_count        = UCNT_W'(uni_q);
          res_d.is_neighbour       = (uni_q == '0) ? (eps_q >= ONE_FIX) : (lhs <= prod_q);
          res_d.overflow           = ovf_rep_q;
          res_valid_d              = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_a_q    <= '0;
      size_b_q    <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      eps_q       <= EPS_RESET;
    end else begin
      state_q     <= state_d;
      size_a_q    <= size_a_d;
      size_b_q    <= size_b_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      if (eps_we_i) eps_q <= eps_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q   <= idx_a_d;
    idx_b_q   <= idx_b_d;
    match_q   <= match_d;
    uni_q     <= uni_d;
    diff_q    <= diff_d;
    prod_q    <= prod_d;
    ovf_rep_q <= ovf_rep_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (idx_a_q <= size_a_q) && (idx_b_q <= size_b_q))
    else $error("merge walk index past list size");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (match_q <= idx_a_q) && (match_q <= idx_b_q))
    else $error("match count exceeds walk progress");

  a_b_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (size_b_q == '0))
    else $error("list B not cleared after compute");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> res_valid_q && (state_q == ST_IDLE))
    else $error("compute result not registered");

  a_size_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_a_q <= CW'(MAX_LABELS)) && (size_b_q <= CW'(MAX_LABELS)))
    else $error("list size beyond capacity");

endmodule

@@ rtl/jaccard_distance_threshold_top.sv @@
// ----------------------------------------------------------------------------
// jaccard_distance_threshold_top
// Jaccard distance threshold unit over two descending-sorted label lists.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// request   push / full                cmd_i, label_i
// result    empty / pop                intersection_count_o, union_count_o,
//                                      is_neighbour_o, overflow_o
// config    eps_fraction_we_i          eps_fraction_i
//
// Appends and clear-A complete in the execute stage without a walk.
// Compute sets up, runs a merge walk of at most |A| + |B| compares,
// then multiplies and loads the result.
// A two-entry request queue lets requests arrive while a compute runs.
// A finished result waits in its register until popped; the compute stalls
// at result load only while the previous result is still unread.
// Reset empties both lists, clears overflow and sets eps to 0.5.
// ----------------------------------------------------------------------------
module jaccard_distance_threshold_top #(
  parameter int MAX_LABELS = 64,
  parameter int LABEL_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [jdt_pkg::CMD_W-1:0]           cmd_i,
  input  logic [jdt_pkg::LABEL_PORT_W-1:0]    label_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [jdt_pkg::ICNT_W-1:0]          intersection_count_o,
  output logic [jdt_pkg::UCNT_W-1:0]          union_count_o,
  output logic                                is_neighbour_o,
  output logic                                overflow_o,
  input  logic                                eps_fraction_we_i,
  input  logic [jdt_pkg::EPS_W-1:0]           eps_fraction_i
);
  import jdt_pkg::*;

  req_t req;
  logic req_valid, req_ready, res_valid;
  res_t res;

  jdt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .label_i     (label_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  jdt_back #(.MAX_LABELS(MAX_LABELS), .LABEL_BITS(LABEL_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .eps_we_i    (eps_fraction_we_i),
    .eps_i       (eps_fraction_i),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign empty                = !res_valid;
  assign intersection_count_o = res.intersection_count;
  assign union_count_o        = res.union_count;
  assign is_neighbour_o       = res.is_neighbour;
  assign overflow_o           = res.overflow;

endmodule
